>>> rtl/core/jerk_limited_scurve_profile_top_assert.svh
// Assertion macros used by the profile generator checker.
`ifndef JERK_LIMITED_SCURVE_PROFILE_TOP_ASSERT_SVH
`define JERK_LIMITED_SCURVE_PROFILE_TOP_ASSERT_SVH
// ante at one edge implies cons at the next, ignored during reset
`define JLSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jlsc assertion failed");
// expression true at every edge outside reset
`define JLSC_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("jlsc assertion failed");
// ante at one edge implies cons at the next, also across reset
`define JLSC_ASSERT_NEXT_RST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("jlsc assertion failed");
`endif

>>> rtl/core/jlsc_pkg.sv
// Shared widths and codes of the jerk-limited profile generator.
package jlsc_pkg;
  localparam int VW    = 32;
  localparam int CW    = 31;
  localparam int DT_W  = 24;
  localparam int OP_W  = 2;
  localparam int MUL_W = 32;
  localparam int DIV_W = 64;

  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_TARGET = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd2;

  localparam logic [1:0] REG_VMAX = 2'd0;
  localparam logic [1:0] REG_AMAX = 2'd1;
  localparam logic [1:0] REG_JMAX = 2'd2;

  localparam logic [CW-1:0] LIMIT_RESET = 31'd65536;
endpackage

>>> rtl/core/jlsc_if.sv
// Request and result channel interfaces of the profile generator.
interface jlsc_req_if import jlsc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OP_W-1:0]        operation;
  logic signed [VW-1:0]   target_position;
  logic signed [VW-1:0]   start_position;
  logic signed [VW-1:0]   start_velocity;
  logic signed [VW-1:0]   start_acceleration;
  logic [DT_W-1:0]        time_step;

  modport source (output valid, operation, target_position, start_position,
                  start_velocity, start_acceleration, time_step, input ready);
  modport sink (input valid, operation, target_position, start_position,
                start_velocity, start_acceleration, time_step, output ready);
endinterface

interface jlsc_res_if import jlsc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] position_out;
  logic signed [VW-1:0] velocity_out;
  logic                 done_res;

  modport source (output valid, position_out, velocity_out, done_res, input ready);
  modport sink (input valid, position_out, velocity_out, done_res, output ready);
endinterface

>>> rtl/core/jlsc_mul.sv
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
module jlsc_mul import jlsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MUL_W-1:0]   a,
  input  logic [MUL_W-1:0]   b,
  output logic               done,
  output logic [2*MUL_W-1:0] prod
);
  localparam int CNT_W = $clog2(MUL_W);

  logic [MUL_W-1:0] mcand;
  logic [MUL_W-1:0] hi;
  logic [MUL_W-1:0] lo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [MUL_W:0]   sum;

  assign sum  = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);
  assign prod = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        mcand <= a;
        hi    <= '0;
        lo    <= b;
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        hi  <= sum[MUL_W:1];
        lo  <= {sum[0], lo[MUL_W-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MUL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> rtl/core/jlsc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module jlsc_div import jlsc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [MUL_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quot
);
  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] dq;
  logic [MUL_W-1:0] rem;
  logic [MUL_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [MUL_W+1:0] diff;
  logic             neg;

  assign diff = {1'b0, rem, dq[DIV_W-1]} - {2'b00, dvs};
  assign neg  = diff[MUL_W+1];
  assign quot = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dq   <= dividend;
        dvs  <= divisor;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= neg ? {rem[MUL_W-2:0], dq[DIV_W-1]} : diff[MUL_W-1:0];
        dq   <= {dq[DIV_W-2:0], ~neg};
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> rtl/core/jerk_limited_scurve_profile_top.sv
// Jerk-limited S-curve profile generator: sequencer, state and APB registers.
// Usage:
//   req_in carries one request per valid/ready transfer: operation 0 runs a
//   tick of time_step/2^24 seconds, 1 loads a new target, 2 loads start state.
//   res_out returns one result per request: position, velocity, done flag.
//   APB writes set the velocity, acceleration and jerk limits (0x0, 0x4, 0x8)
//   and must only happen while no request is in flight.
// Sequence:
//   A moving tick runs a serial multiplier (five products) and a serial
//   divider (two quotients) in turn. Target, load, unused operations and
//   ticks that change nothing go straight from idle to the finish state,
//   which loads the result into the output register.
//   One request is worked on at a time; the next is taken as soon as the
//   result sits in the output register.
// Reset:
//   rst clears state to zero with done set and limits to 1.0; no result is
//   pending afterwards.
// Stall:
//   While res_out is stalled the result holds and the next request may be
//   taken; its own result waits until the output register frees up.
module jerk_limited_scurve_profile_top import jlsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  jlsc_req_if.sink    req_in,
  jlsc_res_if.source  res_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MVV  = 9'b000000010,
    S_D1   = 9'b000000100,
    S_MVA  = 9'b000001000,
    S_D2   = 9'b000010000,
    S_MJD  = 9'b000100000,
    S_MAD  = 9'b001000000,
    S_MVD  = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  localparam logic signed [33:0] SMAX = 34'sd2147483647;
  localparam logic signed [33:0] SMIN = -34'sd2147483648;

  function automatic logic [31:0] mag(input logic signed [31:0] x);
    mag = x[31] ? (~x + 32'd1) : x;
  endfunction

  function automatic logic signed [33:0] ext(input logic signed [31:0] x);
    ext = {{2{x[31]}}, x};
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [33:0] x);
    if (x > SMAX) sat = 32'sh7fffffff;
    else if (x < SMIN) sat = 32'sh80000000;
    else sat = x[31:0];
  endfunction

  function automatic logic signed [33:0] clampsym(input logic signed [33:0] x,
                                                  input logic [30:0] lim);
    logic signed [33:0] l;
    l = $signed({3'b000, lim});
    if (x > l) clampsym = l;
    else if (x < -l) clampsym = -l;
    else clampsym = x;
  endfunction

  function automatic logic [31:0] qcap(input logic [63:0] q);
    qcap = (q > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : q[31:0];
  endfunction

  function automatic logic signed [33:0] signmag(input logic neg, input logic [31:0] m);
    signmag = neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
  endfunction

  state_t state;
  logic [CW-1:0] vmax, amax, jmax;
  logic signed [VW-1:0] pos, vel, acc, goal;
  logic arrived;
  logic [DT_W-1:0] dt;
  logic signed [VW-1:0] dist_start;
  logic [31:0] stop1;
  logic signed [32:0] tacc;

  logic signed [VW-1:0] opos, ovel;
  logic odone, ovalid;

  logic mul_start, mul_done, div_start, div_done;
  logic [MUL_W-1:0] mul_a, mul_b;
  logic [2*MUL_W-1:0] prod;
  logic [DIV_W-1:0] div_n, quot;
  logic [MUL_W-1:0] div_d;

  logic accept, tick_go, fin_load, cfg_wr;
  logic signed [VW-1:0] dist_now;
  logic [32:0] stop_sum;
  logic [31:0] stop;
  logic dir_pos, against, far;
  logic signed [32:0] tacc_next;
  logic signed [33:0] delta, acc_wide, vel_wide;
  logic signed [VW-1:0] acc_next, vel_next, pos_next, dist_new;
  logic crossed;
  logic [MUL_W-1:0] dt_ext;

  jlsc_mul u_mul (.clk, .rst, .start(mul_start), .a(mul_a), .b(mul_b),
                  .done(mul_done), .prod);
  jlsc_div u_div (.clk, .rst, .start(div_start), .dividend(div_n), .divisor(div_d),
                  .done(div_done), .quot);

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_VMAX: prdata = {1'b0, vmax};
      REG_AMAX: prdata = {1'b0, amax};
      REG_JMAX: prdata = {1'b0, jmax};
      default:  prdata = '0;
    endcase
  end

  assign req_in.ready         = (state == S_IDLE);
  assign accept               = req_in.valid && req_in.ready;
  assign tick_go              = (req_in.operation == OP_TICK) && (req_in.time_step != '0) &&
                                (vmax != '0) && (amax != '0) && (jmax != '0);
  assign fin_load             = (state == S_FIN) && (!ovalid || res_out.ready);
  assign res_out.valid        = ovalid;
  assign res_out.position_out = opos;
  assign res_out.velocity_out = ovel;
  assign res_out.done_res     = odone;
  assign dt_ext               = {{(MUL_W-DT_W){1'b0}}, dt};

  assign dist_now = sat(ext(goal) - ext(pos));

  // braking distance and target acceleration
  assign stop_sum  = {1'b0, stop1} + {1'b0, qcap(quot)};
  assign stop      = (stop_sum > 33'h0_7fff_ffff) ? 32'h7fff_ffff : stop_sum[31:0];
  assign dir_pos   = !dist_start[31];
  assign against   = (vel[31] && dir_pos) || (!vel[31] && (vel != '0) && !dir_pos);
  assign far       = mag(dist_start) > stop;
  always_comb begin
    if (against || far) begin
      if (mag(vel) < {1'b0, vmax}) tacc_next = dir_pos ? $signed({2'b00, amax})
                                                       : -$signed({2'b00, amax});
      else tacc_next = '0;
    end else begin
      tacc_next = dir_pos ? -$signed({2'b00, amax}) : $signed({2'b00, amax});
    end
  end

  // jerk-limited acceleration, velocity and position updates
  assign delta    = clampsym({tacc[32], tacc} - ext(acc), prod[54:24]);
  assign acc_wide = clampsym(ext(acc) + delta, amax);
  assign acc_next = acc_wide[31:0];
  assign vel_wide = clampsym(ext(vel) + signmag(acc[31], prod[55:24]), vmax);
  assign vel_next = vel_wide[31:0];
  assign pos_next = sat(ext(pos) + signmag(vel[31], prod[55:24]));
  assign dist_new = sat(ext(goal) - ext(pos_next));
  assign crossed  = (!dist_start[31] && (dist_start != '0) &&
                     (dist_new[31] || dist_new == '0)) ||
                    (dist_start[31] && !dist_new[31]);

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_n     = prod;
    div_d     = '0;
    unique case (state)
      S_IDLE: begin
        mul_start = accept && tick_go && !(dist_now == '0 && vel == '0);
        mul_a     = mag(vel);
        mul_b     = mag(vel);
      end
      S_MVV: begin
        div_start = mul_done;
        div_d     = {amax, 1'b0};
      end
      S_D1: begin
        mul_start = div_done;
        mul_a     = mag(vel);
        mul_b     = mag(acc);
      end
      S_MVA: begin
        div_start = mul_done;
        div_d     = {1'b0, jmax};
      end
      S_D2: begin
        mul_start = div_done;
        mul_a     = {1'b0, jmax};
        mul_b     = dt_ext;
      end
      S_MJD: begin
        mul_start = mul_done;
        mul_a     = mag(acc_next);
        mul_b     = dt_ext;
      end
      S_MAD: begin
        mul_start = mul_done;
        mul_a     = mag(vel_next);
        mul_b     = dt_ext;
      end
      S_MVD, S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      vmax    <= LIMIT_RESET;
      amax    <= LIMIT_RESET;
      jmax    <= LIMIT_RESET;
      pos     <= '0;
      vel     <= '0;
      acc     <= '0;
      goal    <= '0;
      arrived <= 1'b1;
      ovalid  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_VMAX: vmax <= pwdata[CW-1:0];
          REG_AMAX: amax <= pwdata[CW-1:0];
          REG_JMAX: jmax <= pwdata[CW-1:0];
          default: begin
          end
        endcase
      end
      if (fin_load) ovalid <= 1'b1;
      else if (res_out.ready) ovalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state      <= S_FIN;
            dt         <= req_in.time_step;
            dist_start <= dist_now;
            priority if (req_in.operation == OP_TICK) begin
              if (tick_go) begin
                if (dist_now == '0 && vel == '0) begin
                  pos     <= goal;
                  vel     <= '0;
                  acc     <= '0;
                  arrived <= 1'b1;
                end else begin
                  state <= S_MVV;
                end
              end
            end else if (req_in.operation == OP_TARGET) begin
              goal    <= req_in.target_position;
              arrived <= 1'b0;
            end else if (req_in.operation == OP_LOAD) begin
              pos     <= req_in.start_position;
              vel     <= req_in.start_velocity;
              acc     <= req_in.start_acceleration;
              goal    <= req_in.start_position;
              arrived <= 1'b1;
            end else begin
            end
          end
        end
        S_MVV: if (mul_done) state <= S_D1;
        S_D1: begin
          if (div_done) begin
            stop1 <= qcap(quot);
            state <= S_MVA;
          end
        end
        S_MVA: if (mul_done) state <= S_D2;
        S_D2: begin
          if (div_done) begin
            tacc  <= tacc_next;
            state <= S_MJD;
          end
        end
        S_MJD: begin
          if (mul_done) begin
            acc   <= acc_next;
            state <= S_MAD;
          end
        end
        S_MAD: begin
          if (mul_done) begin
            vel   <= vel_next;
            state <= S_MVD;
          end
        end
        S_MVD: begin
          if (mul_done) begin
            state <= S_FIN;
            if (crossed) begin
              pos     <= goal;
              vel     <= '0;
              acc     <= '0;
              arrived <= 1'b1;
            end else begin
              pos     <= pos_next;
              arrived <= 1'b0;
            end
          end
        end
        S_FIN: if (fin_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      opos  <= pos;
      ovel  <= vel;
      odone <= arrived;
    end
  end
endmodule

>>> rtl/core/jlsc_checker.sv
// Port-level checker of the profile generator and its bind.
`include "jerk_limited_scurve_profile_top_assert.svh"
module jlsc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic pready
);
  `JLSC_ASSERT_NEXT_RST(a_rst_clears_result, clk, rst, !out_valid)
  `JLSC_ASSERT_NEXT(a_busy_after_request, clk, rst, in_valid && in_ready, !in_ready)
  `JLSC_ASSERT_NEXT(a_result_holds, clk, rst, out_valid && !out_ready, out_valid)
  `JLSC_ASSERT_ALWAYS(a_pready_high, clk, rst, pready)
endmodule

bind jerk_limited_scurve_profile_top jlsc_checker u_jlsc_checker (
  .clk(clk), .rst(rst), .in_valid(req_in.valid), .in_ready(req_in.ready),
  .out_valid(res_out.valid), .out_ready(res_out.ready), .pready(pready)
);

>>> tb/testbench.sv
// Testbench for the jerk-limited S-curve profile generator: stimulus, profile predictor, checks.
module testbench import jlsc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint VAL_MAX = 64'sd2147483647;
  localparam longint VAL_MIN = -64'sd2147483648;
  localparam longint unsigned MAG_CAP = 64'd2147483648;
  localparam logic [CW-1:0] LIMIT_MAX = '1;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic signed [VW-1:0] tgt;
    logic signed [VW-1:0] spos;
    logic signed [VW-1:0] svel;
    logic signed [VW-1:0] sacc;
    logic [DT_W-1:0]      dt;
  } request_t;

  typedef struct packed {
    logic signed [VW-1:0] pos;
    logic signed [VW-1:0] vel;
    logic                 done;
  } motion_t;

  typedef struct packed {
    request_t req;
    logic     typed;
    motion_t  want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  jlsc_req_if req_if();
  jlsc_res_if res_if();

  jerk_limited_scurve_profile_top dut (
    .clk(clk), .rst(rst), .req_in(req_if), .res_out(res_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // predictor state
  longint unsigned lim_vel = 65536, lim_acc = 65536, lim_jerk = 65536;
  longint cur_pos = 0, cur_vel = 0, cur_acc = 0, cur_goal = 0;
  logic   cur_done = 1'b1;

  motion_t pending_motion[$];
  int errors = 0;
  longint cycles = 0;
  int stall_pct = 0;
  int max_gap = 0;
  int burst_left = 0;

  initial begin
    req_if.valid = 1'b0;
    req_if.operation = OP_TICK;
    req_if.target_position = '0;
    req_if.start_position = '0;
    req_if.start_velocity = '0;
    req_if.start_acceleration = '0;
    req_if.time_step = '0;
    res_if.ready = 1'b1;
  end

  function automatic longint sat32(longint x);
    if (x > VAL_MAX) return VAL_MAX;
    if (x < VAL_MIN) return VAL_MIN;
    return x;
  endfunction

  function automatic longint clamp_sym(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic longint unsigned mag(longint x);
    return (x < 0) ? longint'(-x) : longint'(x);
  endfunction

  function automatic longint scale_by_dt(longint a, longint unsigned dt);
    longint unsigned m;
    m = (mag(a) * dt) >> DT_W;
    if (m > MAG_CAP) m = MAG_CAP;
    return sat32((a < 0) ? -longint'(m) : longint'(m));
  endfunction

  function automatic longint brake_term(longint unsigned x, longint unsigned y,
                                        longint unsigned d);
    longint unsigned q;
    q = (x * y) / d;
    if (q > MAG_CAP) q = MAG_CAP;
    return longint'(q);
  endfunction

  function automatic void settle_at_goal();
    cur_pos = cur_goal;
    cur_vel = 0;
    cur_acc = 0;
    cur_done = 1'b1;
  endfunction

  function automatic void run_tick(longint unsigned dt);
    longint gap_goal, dir, stop, tacc, jstep, delta, prev;
    if (dt == 0 || lim_vel == 0 || lim_acc == 0 || lim_jerk == 0) return;
    gap_goal = sat32(cur_goal - cur_pos);
    if (gap_goal == 0 && cur_vel == 0) begin
      settle_at_goal();
      return;
    end
    dir = (gap_goal >= 0) ? 1 : -1;
    stop = sat32(brake_term(mag(cur_vel), mag(cur_vel), 2 * lim_acc) +
                 brake_term(mag(cur_vel), mag(cur_acc), lim_jerk));
    if ((dir > 0 && cur_vel < 0) || (dir < 0 && cur_vel > 0) ||
        longint'(mag(gap_goal)) > stop)
      tacc = (longint'(mag(cur_vel)) < longint'(lim_vel)) ? dir * longint'(lim_acc) : 0;
    else
      tacc = -dir * longint'(lim_acc);
    jstep = scale_by_dt(longint'(lim_jerk), dt);
    delta = clamp_sym(tacc - cur_acc, jstep);
    cur_acc = sat32(clamp_sym(sat32(cur_acc + delta), longint'(lim_acc)));
    cur_vel = sat32(clamp_sym(sat32(cur_vel + scale_by_dt(cur_acc, dt)), longint'(lim_vel)));
    prev = gap_goal;
    cur_pos = sat32(cur_pos + scale_by_dt(cur_vel, dt));
    gap_goal = sat32(cur_goal - cur_pos);
    if ((prev > 0 && gap_goal <= 0) || (prev < 0 && gap_goal >= 0)) begin
      settle_at_goal();
      return;
    end
    cur_done = 1'b0;
  endfunction

  function automatic motion_t predict_motion(request_t r);
    motion_t m;
    case (r.op)
      OP_TICK: run_tick(longint'(r.dt));
      OP_TARGET: begin
        cur_goal = longint'(r.tgt);
        cur_done = 1'b0;
      end
      OP_LOAD: begin
        cur_pos = longint'(r.spos);
        cur_vel = longint'(r.svel);
        cur_acc = longint'(r.sacc);
        cur_goal = cur_pos;
        cur_done = 1'b1;
      end
      default: ;
    endcase
    m.pos = cur_pos[VW-1:0];
    m.vel = cur_vel[VW-1:0];
    m.done = cur_done;
    return m;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    motion_t w;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_motion.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        w = pending_motion.pop_front();
        if (res_if.position_out !== w.pos) report("position", res_if.position_out, w.pos);
        if (res_if.velocity_out !== w.vel) report("velocity", res_if.velocity_out, w.vel);
        if (res_if.done_res !== w.done) report("done", res_if.done_res, w.done);
      end
    end
  end

  always @(negedge clk) begin
    res_if.ready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_request(request_t r, logic typed, motion_t want);
    int gap;
    motion_t m;
    if (burst_left == 0) begin
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        @(negedge clk) req_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk);
    req_if.valid <= 1'b1;
    req_if.operation <= r.op;
    req_if.target_position <= r.tgt;
    req_if.start_position <= r.spos;
    req_if.start_velocity <= r.svel;
    req_if.start_acceleration <= r.sacc;
    req_if.time_step <= r.dt;
    do @(posedge clk); while (!(req_if.valid && req_if.ready));
    m = predict_motion(r);
    pending_motion.push_back(typed ? want : m);
    burst_left--;
  endtask

  task automatic drain();
    @(negedge clk) req_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_motion.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [CW-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {1'b0, value};
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_VMAX: lim_vel = value;
      REG_AMAX: lim_acc = value;
      default:  lim_jerk = value;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_limits(logic [CW-1:0] v, logic [CW-1:0] a, logic [CW-1:0] j);
    apb_write(REG_VMAX, v);
    apb_write(REG_AMAX, a);
    apb_write(REG_JMAX, j);
  endtask

  function automatic logic signed [VW-1:0] rand_scaled();
    logic signed [VW-1:0] x;
    x = $signed($urandom >> $urandom_range(0, 31));
    return $urandom_range(0, 1) ? -x : x;
  endfunction

  function automatic logic [DT_W-1:0] rand_dt();
    case ($urandom_range(0, 3))
      0: return DT_W'($urandom_range(1, 16'hFFFF));
      1: return DT_W'($urandom_range(1, 24'h0FFFFF));
      2: return DT_W'($urandom_range(0, 24'hFFFFFF));
      default: return DT_W'($urandom_range(24'h100000, 24'h400000));
    endcase
  endfunction

  function automatic request_t rand_request();
    request_t r;
    r.op = OP_W'($urandom_range(0, 3));
    r.tgt = $urandom;
    r.spos = $urandom;
    r.svel = $urandom_range(0, 1) ? $signed($urandom) : rand_scaled();
    r.sacc = $urandom_range(0, 1) ? $signed($urandom) : rand_scaled();
    r.dt = rand_dt();
    return r;
  endfunction

  // load, new goal, then a run of ticks toward it
  task automatic move_sequence(inout int sent);
    request_t r;
    motion_t none;
    longint goal;
    int n;
    none = '0;
    r = rand_request();
    r.op = OP_LOAD;
    r.svel = $urandom_range(0, 2) ? (rand_scaled() >>> 8) : rand_scaled();
    r.sacc = $urandom_range(0, 2) ? (rand_scaled() >>> 8) : rand_scaled();
    send_request(r, 1'b0, none);
    goal = sat32(longint'(r.spos) + longint'(rand_scaled()));
    r.op = OP_TARGET;
    r.tgt = goal[VW-1:0];
    send_request(r, 1'b0, none);
    n = $urandom_range(4, 24);
    sent += 2 + n;
    repeat (n) begin
      r.op = OP_TICK;
      r.dt = rand_dt();
      send_request(r, 1'b0, none);
    end
  endtask

  function automatic step_row_t row(logic [OP_W-1:0] op, logic [31:0] tgt, logic [31:0] sp,
                                    logic [31:0] sv, logic [31:0] sa, logic [DT_W-1:0] dt,
                                    logic typed, logic [31:0] ep, logic [31:0] ev, logic ed);
    step_row_t s;
    s.req = '{op, tgt, sp, sv, sa, dt};
    s.typed = typed;
    s.want = '{ep, ev, ed};
    return s;
  endfunction

  step_row_t directed_rows[$];

  initial begin
    int sent;
    int phase;
    logic [OP_W-1:0] unused_op;
    request_t r;
    motion_t none;
    none = '0;
    unused_op = '1;
    directed_rows = '{
      row(OP_TICK,   0, 0, 0, 0, 24'd1,       1, 0, 0, 1),
      row(unused_op, '1, '1, '1, '1, '1,      1, 0, 0, 1),
      row(OP_TICK,   0, 0, 0, 0, 24'd0,       1, 0, 0, 1),
      row(OP_LOAD,   0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0,
          1, 32'h7FFFFFFF, 32'h80000000, 1),
      row(OP_TICK,   0, 0, 0, 0, 24'hFFFFFF,  0, 0, 0, 0),
      row(OP_TICK,   0, 0, 0, 0, 24'd1,       0, 0, 0, 0),
      row(OP_TARGET, 32'h80000000, 0, 0, 0, 0, 0, 0, 0, 0),
      row(OP_TICK,   0, 0, 0, 0, 24'hFFFFFF,  0, 0, 0, 0),
      row(OP_TICK,   0, 0, 0, 0, 24'hFFFFFF,  0, 0, 0, 0),
      row(OP_LOAD,   0, 32'h80000000, 0, 0, 0, 1, 32'h80000000, 0, 1),
      row(OP_TARGET, 32'h7FFFFFFF, 0, 0, 0, 0, 1, 32'h80000000, 0, 0),
      row(OP_TICK,   0, 0, 0, 0, 24'd0,       1, 32'h80000000, 0, 0),
      row(OP_TICK,   0, 0, 0, 0, 24'hFFFFFF,  0, 0, 0, 0),
      row(OP_TICK,   0, 0, 0, 0, 24'hFFFFFF,  0, 0, 0, 0),
      row(OP_TICK,   0, 0, 0, 0, 24'hFFFFFF,  0, 0, 0, 0),
      row(OP_LOAD,   0, 0, 0, 0, 0,           1, 0, 0, 1),
      row(OP_TARGET, 0, 0, 0, 0, 0,           1, 0, 0, 0),
      row(OP_TICK,   0, 0, 0, 0, 24'hFFFFFF,  1, 0, 0, 1),
      row(OP_LOAD,   0, 0, 32'h00010000, 0, 0, 1, 0, 32'h00010000, 1),
      row(OP_TARGET, 32'h00000100, 0, 0, 0, 0, 1, 0, 32'h00010000, 0),
      row(OP_TICK,   0, 0, 0, 0, 24'h400000,  0, 0, 0, 0),
      row(OP_LOAD,   0, 32'h00050000, 32'hFFFE0000, 32'hFFFF0000, 0,
          1, 32'h00050000, 32'hFFFE0000, 1),
      row(OP_TARGET, 32'h00100000, 0, 0, 0, 0, 0, 0, 0, 0),
      row(OP_TICK,   0, 0, 0, 0, 24'h200000,  0, 0, 0, 0),
      row(OP_TICK,   0, 0, 0, 0, 24'h200000,  0, 0, 0, 0)
    };

    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    drain();

    sent = 0;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_limits(31'd65536 * 4, 31'd65536 * 2, 31'd65536 * 8);
        1: set_limits(LIMIT_MAX, LIMIT_MAX, LIMIT_MAX);
        2: set_limits(31'd1, 31'd1, 31'd1);
        3: set_limits(LIMIT_MAX, 31'd1, CW'($urandom_range(1, 32'h7FFFFFFF)));
        default: set_limits(CW'($urandom_range(1, 32'h7FFFFFFF) >> $urandom_range(0, 14)),
                            CW'($urandom_range(1, 32'h7FFFFFFF) >> $urandom_range(0, 14)),
                            CW'($urandom_range(1, 32'h7FFFFFFF) >> $urandom_range(0, 14)));
      endcase
      stall_pct = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 30 : 70;
      max_gap = (phase % 2 == 0) ? 0 : 6;
      while (sent < 240 * (phase + 1)) begin
        if ($urandom_range(0, 9) < 8) begin
          move_sequence(sent);
        end else begin
          r = rand_request();
          send_request(r, 1'b0, none);
          sent++;
        end
        if ($urandom_range(0, 99) == 0) drain();
      end
      drain();
    end

    stall_pct = 0;
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
